// File: hw/rtl/pac_pkg.sv
// Shared constants and register codes for the periodic autocorrelation check.
package pac_pkg;

  localparam int SIGN_W     = 31;
  localparam int LEN_W      = 6;
  localparam int BOUND_W    = 5;
  localparam int SHIFT_W    = 5;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int MIN_LEN    = 3;

  localparam logic [LEN_W-1:0]   SEQ_LENGTH_RST = 6'd30;
  localparam logic [BOUND_W-1:0] CORR_BOUND_RST = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_LENGTH = 1'b0,
    CFG_CORR_BOUND = 1'b1
  } cfg_reg_t;

endpackage

// File: hw/rtl/periodic_autocorrelation_check.sv
// Top level of the periodic autocorrelation sidelobe check pipeline.
// A beat passes through stage 1, stage 2, stage 3 and the output register before it shows on out_valid.
// Throughput: one beat per cycle while out_ready stays high; every stage has its own valid bit and holds under stall.
// The output register frees as soon as its beat is taken, so bubbles close up.
// Reset clears all valid bits and loads seq_length with 30 and corr_bound with 2.
// Payload registers are not reset.
module periodic_autocorrelation_check #(
  parameter int MAX_LEN = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [pac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pac_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pac_pkg::SIGN_W-1:0]         sign_bits,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               passed,
  output logic [pac_pkg::SHIFT_W-1:0]        first_bad_shift,
  output logic [pac_pkg::SIGN_W-1:0]         echo_bits
);
  import pac_pkg::*;

  // Width of an effective length, of a position index and of a lag sum.
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int PW  = $clog2(MAX_LEN);
  localparam int AW  = LW + 2;
  localparam int LCW = (LW > LEN_W) ? LW : LEN_W;
  localparam int CW  = ((AW + 1) > (BOUND_W + 2)) ? (AW + 1) : (BOUND_W + 2);

  // Configuration registers.
  logic [LEN_W-1:0]   seq_length;
  logic [BOUND_W-1:0] corr_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= SEQ_LENGTH_RST;
      corr_bound <= CORR_BOUND_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SEQ_LENGTH: seq_length <= cfg_data[LEN_W-1:0];
        CFG_CORR_BOUND: corr_bound <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // The length in use is clamped to the range the hardware supports. The user
  // must change the registers only while the pipeline is empty, so every stage
  // may look at them directly; the block itself does not enforce this.
  logic [LCW-1:0] len_wide;
  logic [LW-1:0]  len_eff;

  always_comb begin
    len_wide = LCW'(seq_length);
    if (len_wide < LCW'(MIN_LEN)) begin
      len_wide = LCW'(MIN_LEN);
    end else if (len_wide > LCW'(MAX_LEN)) begin
      len_wide = LCW'(MAX_LEN);
    end
    len_eff = len_wide[LW-1:0];
  end

  // Handshake: each stage loads when it is empty or the stage after it moves.
  logic s1_valid, s2_valid, s3_valid;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid <= in_valid;
      end
      if (rdy2) begin
        s2_valid <= s1_valid;
      end
      if (rdy3) begin
        s3_valid <= s2_valid;
      end
      if (rdy4) begin
        out_valid <= s3_valid;
      end
    end
  end

  // Stage 1: expand the beat into a sign vector and a live-position mask.
  // Position 0 is the zero and never live; positions with no sign bit are -1.
  logic [MAX_LEN-1:0] sv_in, mask_in;
  logic [MAX_LEN-1:0] s1_sv, s1_mask;
  logic [SIGN_W-1:0]  s1_bits;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_pos
    if (j == 0) begin : g_zero
      assign sv_in[j]   = 1'b0;
      assign mask_in[j] = 1'b0;
    end else begin : g_live
      if (j - 1 < SIGN_W) begin : g_bit
        assign sv_in[j] = sign_bits[j-1];
      end else begin : g_neg
        assign sv_in[j] = 1'b0;
      end
      assign mask_in[j] = (len_eff > LW'(j));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sv   <= sv_in;
      s1_mask <= mask_in;
      s1_bits <= sign_bits;
    end
  end

  // Stage 2: aperiodic correlation A(d) for every lag. With positions at or
  // beyond L masked out, the periodic value is C(k) = A(k) + A(L - k).
  logic signed [AW-1:0] s2_corr [MAX_LEN];
  logic [SIGN_W-1:0]    s2_bits;

  pac_lags #(
    .MAX_LEN (MAX_LEN)
  ) u_lags (
    .clk  (clk),
    .en   (rdy2),
    .sv   (s1_sv),
    .mask (s1_mask),
    .len  (len_eff),
    .corr (s2_corr)
  );

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_bits <= s1_bits;
    end
  end

  // Stage 3: fold the two halves of each cyclic shift and compare the
  // magnitude against the bound. Shifts at or beyond L are never flagged.
  logic signed [CW-1:0] bound_s;
  logic [MAX_LEN-1:1]   bad_in;
  logic [MAX_LEN-1:1]   s3_bad;
  logic [SIGN_W-1:0]    s3_bits;

  assign bound_s = CW'($signed({1'b0, corr_bound}));

  for (genvar k = 1; k < MAX_LEN; k++) begin : g_shift
    logic                 live;
    logic [LW-1:0]        mirror;
    logic [PW-1:0]        mirror_sel;
    logic signed [CW-1:0] csum;

    assign live       = (len_eff > LW'(k));
    assign mirror     = len_eff - LW'(k);
    assign mirror_sel = live ? mirror[PW-1:0] : PW'(k);
    assign csum       = CW'(s2_corr[k]) + CW'(s2_corr[mirror_sel]);
    assign bad_in[k]  = live && ((csum > bound_s) || (csum < -bound_s));
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_bad  <= bad_in;
      s3_bits <= s2_bits;
    end
  end

  // Stage 4: the lowest flagged shift wins; the result sits in the output
  // register until the beat is taken.
  logic [PW-1:0] first_k;

  always_comb begin
    first_k = '0;
    for (int k = MAX_LEN - 1; k >= 1; k--) begin
      if (s3_bad[k]) begin
        first_k = PW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      passed          <= ~|s3_bad;
      first_bad_shift <= SHIFT_W'(first_k);
      echo_bits       <= s3_bits;
    end
  end

  // An accepted beat always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted beat missing from stage 1");

  // A stalled third stage keeps its flags.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !rdy4) |=> (s3_valid && $stable(s3_bad) && $stable(s3_bits)))
    else $error("stage 3 changed while stalled");

  // A passing result reports no failing shift.
  a_pass_shift: assert property (@(posedge clk) disable iff (rst)
    (out_valid && passed) |-> (first_bad_shift == '0))
    else $error("passing result carries a failing shift");

endmodule

// File: hw/rtl/pac_lags.sv
// Registered aperiodic autocorrelation of the masked sequence at every lag.
module pac_lags #(
  parameter int MAX_LEN = 32,
  localparam int CNT_W  = $clog2(MAX_LEN + 1),
  localparam int AW     = CNT_W + 2
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MAX_LEN-1:0]   sv,
  input  logic [MAX_LEN-1:0]   mask,
  input  logic [CNT_W-1:0]     len,
  output logic signed [AW-1:0] corr [MAX_LEN]
);

  // Lag zero is never looked at as a sidelobe; it is held at zero.
  always_ff @(posedge clk) begin
    if (en) begin
      corr[0] <= '0;
    end
  end

  for (genvar d = 1; d < MAX_LEN; d++) begin : g_lag
    logic [MAX_LEN-1:0] agree_vec;
    logic [CNT_W-1:0]   agree;
    logic [CNT_W-1:0]   terms;

    // A pair counts when both positions are live and their signs agree.
    assign agree_vec = mask & (mask << d) & ~(sv ^ (sv << d));
    assign agree     = CNT_W'($countones(agree_vec));
    // Live pairs at lag d: positions d+1 .. L-1.
    assign terms     = (len > CNT_W'(d + 1)) ? (len - CNT_W'(d + 1)) : '0;

    always_ff @(posedge clk) begin
      if (en) begin
        corr[d] <= $signed({1'b0, agree, 1'b0}) - $signed({2'b00, terms});
      end
    end
  end

endmodule

// File: tb/pac_result_checker.sv
// Checker that predicts and compares every result beat of the autocorrelation check.
`timescale 1ns / 100ps
module pac_result_checker #(
  parameter int MAX_LEN = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [pac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pac_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [pac_pkg::SIGN_W-1:0]         sign_bits,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               passed,
  input  logic [pac_pkg::SHIFT_W-1:0]        first_bad_shift,
  input  logic [pac_pkg::SIGN_W-1:0]         echo_bits,
  output int                                 mismatches,
  output int                                 outstanding
);

  typedef struct packed {
    logic                            passed;
    logic [pac_pkg::SHIFT_W-1:0]     shift;
    logic [pac_pkg::SIGN_W-1:0]      echo;
  } verdict_t;

  verdict_t                        verdict_q[$];
  logic [pac_pkg::LEN_W-1:0]       len_reg;
  logic [pac_pkg::BOUND_W-1:0]     bound_reg;
  int                              fail_total = 0;

  // Works out the periodic autocorrelation at every shift and reports the first one
  // whose magnitude goes past the bound.
  function automatic verdict_t predict_verdict(input logic [pac_pkg::SIGN_W-1:0] bits,
                                               input logic [pac_pkg::LEN_W-1:0] len_cfg,
                                               input logic [pac_pkg::BOUND_W-1:0] bound_cfg);
    int       len;
    int       sum;
    int       bad;
    int       seq [MAX_LEN];
    verdict_t v;
    len = int'(len_cfg);
    if (len < pac_pkg::MIN_LEN) len = pac_pkg::MIN_LEN;
    if (len > MAX_LEN) len = MAX_LEN;
    seq[0] = 0;
    // Positions with no sign bit behind them count as minus one.
    for (int j = 1; j < len; j++)
      seq[j] = (j - 1 >= pac_pkg::SIGN_W) ? -1 : (bits[j-1] ? 1 : -1);
    bad = 0;
    for (int k = 1; k < len && bad == 0; k++) begin
      sum = 0;
      for (int j = 0; j < len; j++)
        sum += seq[j] * seq[(j >= k) ? j - k : j + len - k];
      if (sum < 0) sum = -sum;
      if (sum > int'(bound_cfg)) bad = k;
    end
    v.passed = (bad == 0);
    v.shift  = bad[pac_pkg::SHIFT_W-1:0];
    v.echo   = bits;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst) begin
      verdict_q.delete();
      len_reg     <= pac_pkg::SEQ_LENGTH_RST;
      bound_reg   <= pac_pkg::CORR_BOUND_RST;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {passed, first_bad_shift, echo_bits};
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat: passed %0b shift %0d echo %h",
                   $time, got.passed, got.shift, got.echo);
          fail_total++;
        end else begin
          want = verdict_q.pop_front();
          if (got.passed !== want.passed) begin
            $display("%0t: passed expected %0b actual %0b", $time, want.passed, got.passed);
            fail_total++;
          end
          if (got.shift !== want.shift) begin
            $display("%0t: first_bad_shift expected %0d actual %0d",
                     $time, want.shift, got.shift);
            fail_total++;
          end
          if (got.echo !== want.echo) begin
            $display("%0t: echo_bits expected %h actual %h", $time, want.echo, got.echo);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready)
        verdict_q.push_back(predict_verdict(sign_bits, len_reg, bound_reg));
      if (cfg_wr_en) begin
        if (cfg_index == pac_pkg::CFG_SEQ_LENGTH)
          len_reg <= cfg_data[pac_pkg::LEN_W-1:0];
        else if (cfg_index == pac_pkg::CFG_CORR_BOUND)
          bound_reg <= cfg_data[pac_pkg::BOUND_W-1:0];
      end
      mismatches  <= fail_total;
      outstanding <= verdict_q.size();
    end
  end

endmodule

// File: tb/tb_periodic_autocorrelation_check.sv
// Testbench top for the periodic autocorrelation check: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_periodic_autocorrelation_check;
  import pac_pkg::*;

  localparam int MAX_LEN         = 32;
  // This limit leaves a wide margin over a correct run, even with heavy idling on both sides.
  localparam int CYCLE_LIMIT     = 200000;
  // Cycles waited after the drain for any stray result beat.
  localparam int DRAIN_CYCLES    = 12;
  localparam int PHASES          = 14;
  localparam int BEATS_PER_PHASE = 102;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idling_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic [SIGN_W-1:0]        sign_bits = '0;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic                     passed;
  logic [SHIFT_W-1:0]       first_bad_shift;
  logic [SIGN_W-1:0]        echo_bits;
  int                       mismatches;
  int                       outstanding;
  int                       cycle_count    = 0;
  int                       send_idle_pct  = 0;
  int                       recv_stall_pct = 0;

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  periodic_autocorrelation_check #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sign_bits       (sign_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .passed          (passed),
    .first_bad_shift (first_bad_shift),
    .echo_bits       (echo_bits)
  );

  pac_result_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sign_bits       (sign_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .passed          (passed),
    .first_bad_shift (first_bad_shift),
    .echo_bits       (echo_bits),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // The receiver decides afresh at every edge whether it will take a result beat, so
  // stalls land on every stage of the pipeline.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one candidate beat. The sender may idle first; once valid is raised it stays
  // high with the same signs until the block accepts the beat. The task returns in the
  // time step of the accepting edge, so the next call can keep valid high without a gap.
  task automatic send_candidate(input logic [SIGN_W-1:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sign_bits <= bits;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every predicted result has been seen. The first edge lets the checker
  // count a beat accepted in the current time step.
  task automatic wait_for_drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Writes seq_length and then corr_bound; only done with the pipeline empty.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] len_value,
                               input logic [CFG_DATA_W-1:0] bound_value);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SEQ_LENGTH;
    cfg_data  <= len_value;
    @(posedge clk);
    cfg_index <= CFG_CORR_BOUND;
    cfg_data  <= bound_value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct  = 55;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 55;
      end
      default: begin
        send_idle_pct  = 21;
        recv_stall_pct = 21;
      end
    endcase
  endtask

  initial begin
    logic [SIGN_W-1:0]     candidate;
    logic [CFG_DATA_W-1:0] len_sel;
    logic [CFG_DATA_W-1:0] bound_sel;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset setting (length 30, bound 2). They cover all-minus
    // and all-plus signs, alternating patterns, single set bits at both ends, and the
    // two top sign bits, which lie past the sequence and must only be echoed.
    send_candidate(31'h0000_0000);
    send_candidate(31'h7FFF_FFFF);
    send_candidate(31'h5555_5555);
    send_candidate(31'h2AAA_AAAA);
    send_candidate(31'h0000_0001);
    send_candidate(31'h1000_0000);
    send_candidate(31'h2000_0000);
    send_candidate(31'h4000_0000);
    send_candidate(31'h6000_0000);
    send_candidate(31'h1FFF_FFFF);
    send_candidate(31'h0F0F_0F0F);
    send_candidate(31'h3333_3333);
    send_candidate(31'h0123_4567);
    send_candidate(31'h7654_3210);

    // Each phase starts from an empty pipeline, writes a fresh setting and then runs a
    // block of random beats under one of the four idling modes.
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_for_drain();
      case (p)
        // Length zero is taken as the shortest length; a zero bound fails every candidate.
        0: begin
          len_sel   = 6'd0;
          bound_sel = 6'd0;
        end
        1: begin
          len_sel   = 6'd3;
          bound_sel = 6'd1;
        end
        // Length two is clamped up; bit five of the bound is dropped, leaving 31.
        2: begin
          len_sel   = 6'd2;
          bound_sel = 6'd63;
        end
        // Full length with the largest bound: every candidate passes.
        3: begin
          len_sel   = 6'd32;
          bound_sel = 6'd31;
        end
        // Lengths past the maximum are clamped down.
        4: begin
          len_sel   = 6'd63;
          bound_sel = 6'd2;
        end
        5: begin
          len_sel   = 6'd33;
          bound_sel = 6'd33;
        end
        // Middling bounds push the first failing shift well past one.
        6: begin
          len_sel   = 6'd32;
          bound_sel = 6'd10;
        end
        7: begin
          len_sel   = 6'd16;
          bound_sel = 6'd4;
        end
        default: begin
          len_sel   = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(63))
                                               : CFG_DATA_W'($urandom_range(32, 3));
          bound_sel = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(63))
                                               : CFG_DATA_W'($urandom_range(12));
        end
      endcase
      apply_setting(len_sel, bound_sel);
      set_idling(idling_t'(p % 4));

      // Sparse and dense sign patterns as well as plain random ones, so that the sums
      // spread over a wide range of magnitudes.
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        case ($urandom_range(3))
          0:       candidate = SIGN_W'($urandom & $urandom);
          1:       candidate = SIGN_W'($urandom | $urandom);
          default: candidate = SIGN_W'($urandom);
        endcase
        send_candidate(candidate);
      end
    end

    in_valid <= 1'b0;
    wait_for_drain();
    // Waiting on after the drain catches any stray result beat the block might still produce.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pac_pkg.sv
hw/rtl/pac_lags.sv
hw/rtl/periodic_autocorrelation_check.sv
tb/pac_result_checker.sv
tb/tb_periodic_autocorrelation_check.sv
